// ===== sv/inner_rectangle_grow_core_defines.svh =====
// assertion macros shared by the checker of the rectangle grow core
// no dependencies; taken in by `include
`ifndef INNER_RECTANGLE_GROW_CORE_DEFINES_SVH
`define INNER_RECTANGLE_GROW_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define IRG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("irg checker: same-cycle property failed");

// next-cycle implication, disabled while reset is low
`define IRG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("irg checker: next-cycle property failed");

`endif

// ===== sv/irg_pkg.sv =====
// shared constants of the rectangle grow core
// no dependencies
package irg_pkg;

    // default sizing
    localparam int IRG_MAX_DIM       = 64;
    localparam int IRG_FULLNESS_BITS = 2;

    // item opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_GROW  = 1'b1;

    // register index (paddr bit 2)
    localparam logic REG_DIM_X = 1'b0;
    localparam logic REG_DIM_Y = 1'b1;

endpackage

// ===== sv/irg_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module irg_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/irg_div.sv =====
// restoring shift-subtract divider, one quotient bit per cycle
// no dependencies
module irg_div #(
    parameter int NW = 12,
    parameter int DW = 7,
    localparam int CNTW = (NW > 1) ? $clog2(NW) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [NW-1:0] o_quotient,
    output logic [DW-1:0] o_remainder
);

    logic            r_run, n_run;
    logic            r_done, n_done;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [NW-1:0]   r_quo, n_quo;
    logic [DW-1:0]   r_rem, n_rem;
    logic [DW-1:0]   r_dv, n_dv;

    logic [DW:0]     rem_sh;
    logic [DW:0]     diff;
    logic            ge;

    always_comb begin
        rem_sh = {r_rem, r_quo[NW-1]};
        diff   = rem_sh - {1'b0, r_dv};
        ge     = (rem_sh >= {1'b0, r_dv});

        n_run  = r_run;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dv   = r_dv;

        if (i_start) begin
            n_run = 1'b1;
            n_cnt = '0;
            n_quo = i_dividend;
            n_rem = '0;
            n_dv  = i_divisor;
        end else if (r_run) begin
            n_rem = ge ? diff[DW-1:0] : rem_sh[DW-1:0];
            n_quo = {r_quo[NW-2:0], ge};
            n_cnt = r_cnt + CNTW'(1);
            if (r_cnt == CNTW'(NW - 1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dv  <= n_dv;
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ===== sv/inner_rectangle_grow_core.sv =====
// top level of the rectangle grow core: pixel store, seed divider, growth sequencer
// depends on irg_pkg, irg_ram, irg_div
//
//  channel   | handshake                         | payload
//  ----------+-----------------------------------+------------------------------------------
//  item in   | start & !busy                     | i_opcode, i_pixel_index, i_fullness
//  result    | o_done, one cycle, no back-press  | o_seed_inside, o_x_low/y_low/x_high/y_high
//  config    | psel & penable & pwrite & pready  | paddr, pwdata, prdata
//
//  a write item goes straight into the store and busy never rises for it
//  a grow item runs the divider, then the seed read (S_SEED) and seed check (S_SEEDCHK); then
//  per side attempt an S_SIDE step plus, when the side is not at the edge, an S_SCAN of pixel
//  reads over the span, and one last S_SIDE step that sees every side stopped; the single pixel read
//  port with its address multiply-add sets this
//  o_done pulses once per grow item, in the cycle busy falls; the receiver cannot stall
//  reset is synchronous, active low; the pixel store is not cleared and needs writes first
module inner_rectangle_grow_core #(
    parameter int MAX_DIM       = irg_pkg::IRG_MAX_DIM,
    parameter int FULLNESS_BITS = irg_pkg::IRG_FULLNESS_BITS,
    localparam int CW           = $clog2(MAX_DIM),
    localparam int DW           = $clog2(MAX_DIM + 1),
    localparam int IW           = 2 * CW
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // item channel
    input  logic                     start,
    output logic                     busy,
    input  logic                     i_opcode,
    input  logic [IW-1:0]            i_pixel_index,
    input  logic [FULLNESS_BITS-1:0] i_fullness,
    // result channel
    output logic                     o_done,
    output logic                     o_seed_inside,
    output logic [CW-1:0]            o_x_low,
    output logic [CW-1:0]            o_y_low,
    output logic [CW-1:0]            o_x_high,
    output logic [CW-1:0]            o_y_high,
    // config port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = CW + DW;
    localparam logic [FULLNESS_BITS-1:0] FULL = {FULLNESS_BITS{1'b1}};

    // sequencer states
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DIV     = 3'd1;
    localparam logic [2:0] S_SEED    = 3'd2;
    localparam logic [2:0] S_SEEDCHK = 3'd3;
    localparam logic [2:0] S_SIDE    = 3'd4;
    localparam logic [2:0] S_SCAN    = 3'd5;

    // growth sides, visited in this order
    localparam logic [1:0] SIDE_LEFT   = 2'd0;
    localparam logic [1:0] SIDE_BOTTOM = 2'd1;
    localparam logic [1:0] SIDE_RIGHT  = 2'd2;
    localparam logic [1:0] SIDE_TOP    = 2'd3;

    // config registers (raw value kept, clamped on use)
    logic [DW-1:0] r_dim_x, r_dim_y;
    logic [DW-1:0] dx_eff, dy_eff;

    // sequencer state
    logic [2:0]    r_state, n_state;
    logic [1:0]    r_side, n_side;
    logic [3:0]    r_stop, n_stop;
    logic [CW-1:0] r_xl, n_xl, r_xh, n_xh, r_yl, n_yl, r_yh, n_yh;

    // scan of one candidate column or row
    logic [CW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_end, n_end;
    logic [CW-1:0] r_fix, n_fix;
    logic          r_vert, n_vert;
    logic          r_iss, n_iss;
    logic          r_rd_vld, n_rd_vld;
    logic          r_rd_last, n_rd_last;

    // result registers
    logic          r_done, n_done;
    logic          r_res_in, n_res_in;
    logic [CW-1:0] r_res_xl, n_res_xl, r_res_yl, n_res_yl;
    logic [CW-1:0] r_res_xh, n_res_xh, r_res_yh, n_res_yh;

    // side decode
    logic          side_bnd;
    logic [CW-1:0] side_fix, side_start, side_end;
    logic          side_vert;

    // store access
    logic                     item_acc;
    logic                     wr_en;
    logic [CW-1:0]            ax, ay;
    logic [PW-1:0]            addr_full;
    logic [AW-1:0]            rd_addr;
    logic [FULLNESS_BITS-1:0] rd_data;

    // divider
    logic          div_start, div_done;
    logic [IW-1:0] div_quo;
    logic [DW-1:0] div_rem;

    assign busy     = (r_state != S_IDLE);
    assign item_acc = start && !busy;
    assign pready   = 1'b1;

    // dimension clamp: zero acts as one, above the store acts as the store size
    always_comb begin
        if (r_dim_x == '0) begin
            dx_eff = DW'(1);
        end else if (r_dim_x > DW'(MAX_DIM)) begin
            dx_eff = DW'(MAX_DIM);
        end else begin
            dx_eff = r_dim_x;
        end
        if (r_dim_y == '0) begin
            dy_eff = DW'(1);
        end else if (r_dim_y > DW'(MAX_DIM)) begin
            dy_eff = DW'(MAX_DIM);
        end else begin
            dy_eff = r_dim_y;
        end
    end

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_x <= DW'(MAX_DIM);
            r_dim_y <= DW'(MAX_DIM);
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                irg_pkg::REG_DIM_X: r_dim_x <= pwdata[DW-1:0];
                irg_pkg::REG_DIM_Y: r_dim_y <= pwdata[DW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            irg_pkg::REG_DIM_X: prdata = 32'(r_dim_x);
            irg_pkg::REG_DIM_Y: prdata = 32'(r_dim_y);
            default:            prdata = '0;
        endcase
    end

    // pixel store: writes straight from the item, reads from the sequencer
    assign wr_en = item_acc && (i_opcode == irg_pkg::OP_WRITE)
                   && (32'(i_pixel_index) < DEPTH);

    // one multiply-add forms every read address: y*dim_x + x
    always_comb begin
        if (r_state == S_SEED) begin
            ax = r_xl;
            ay = r_yl;
        end else begin
            ax = r_vert ? r_fix : r_pos;
            ay = r_vert ? r_pos : r_fix;
        end
        addr_full = PW'(ay) * PW'(dx_eff) + PW'(ax);
        rd_addr   = addr_full[AW-1:0];
    end

    irg_ram #(
        .WIDTH (FULLNESS_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (i_pixel_index[AW-1:0]),
        .i_wdata (i_fullness),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // seed index split into column (remainder) and row (quotient)
    assign div_start = item_acc && (i_opcode == irg_pkg::OP_GROW);

    irg_div #(
        .NW (IW),
        .DW (DW)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (i_pixel_index),
        .i_divisor   (dx_eff),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // candidate column or row for the current side
    always_comb begin
        side_bnd   = 1'b1;
        side_fix   = r_xl - CW'(1);
        side_start = r_yl;
        side_end   = r_yh;
        side_vert  = 1'b1;
        case (r_side)
            SIDE_LEFT: begin
                side_bnd   = (r_xl == '0);
                side_fix   = r_xl - CW'(1);
                side_start = r_yl;
                side_end   = r_yh;
                side_vert  = 1'b1;
            end
            SIDE_BOTTOM: begin
                side_bnd   = (r_yl == '0);
                side_fix   = r_yl - CW'(1);
                side_start = r_xl;
                side_end   = r_xh;
                side_vert  = 1'b0;
            end
            SIDE_RIGHT: begin
                side_bnd   = (DW'(r_xh) + DW'(1) >= dx_eff);
                side_fix   = r_xh + CW'(1);
                side_start = r_yl;
                side_end   = r_yh;
                side_vert  = 1'b1;
            end
            SIDE_TOP: begin
                side_bnd   = (DW'(r_yh) + DW'(1) >= dy_eff);
                side_fix   = r_yh + CW'(1);
                side_start = r_xl;
                side_end   = r_xh;
                side_vert  = 1'b0;
            end
            default: ;
        endcase
    end

    // growth sequencer
    always_comb begin
        n_state   = r_state;
        n_side    = r_side;
        n_stop    = r_stop;
        n_xl      = r_xl;
        n_xh      = r_xh;
        n_yl      = r_yl;
        n_yh      = r_yh;
        n_pos     = r_pos;
        n_end     = r_end;
        n_fix     = r_fix;
        n_vert    = r_vert;
        n_iss     = r_iss;
        n_rd_vld  = 1'b0;
        n_rd_last = r_rd_last;
        n_done    = 1'b0;
        n_res_in  = r_res_in;
        n_res_xl  = r_res_xl;
        n_res_yl  = r_res_yl;
        n_res_xh  = r_res_xh;
        n_res_yh  = r_res_yh;

        case (r_state)
            S_IDLE: begin
                if (div_start) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    // row beyond the raster means the seed lies outside it
                    if (div_quo < IW'(dy_eff)) begin
                        n_xl    = div_rem[CW-1:0];
                        n_xh    = div_rem[CW-1:0];
                        n_yl    = div_quo[CW-1:0];
                        n_yh    = div_quo[CW-1:0];
                        n_state = S_SEED;
                    end else begin
                        n_done   = 1'b1;
                        n_res_in = 1'b0;
                        n_res_xl = '0;
                        n_res_yl = '0;
                        n_res_xh = '0;
                        n_res_yh = '0;
                        n_state  = S_IDLE;
                    end
                end
            end
            S_SEED: begin
                n_state = S_SEEDCHK;
            end
            S_SEEDCHK: begin
                if (rd_data == FULL) begin
                    n_stop  = '0;
                    n_side  = SIDE_LEFT;
                    n_state = S_SIDE;
                end else begin
                    n_done   = 1'b1;
                    n_res_in = 1'b0;
                    n_res_xl = '0;
                    n_res_yl = '0;
                    n_res_xh = '0;
                    n_res_yh = '0;
                    n_state  = S_IDLE;
                end
            end
            S_SIDE: begin
                if (&r_stop) begin
                    n_done   = 1'b1;
                    n_res_in = 1'b1;
                    n_res_xl = r_xl;
                    n_res_yl = r_yl;
                    n_res_xh = r_xh;
                    n_res_yh = r_yh;
                    n_state  = S_IDLE;
                end else if (r_stop[r_side]) begin
                    n_side = r_side + 2'd1;
                end else if (side_bnd) begin
                    n_stop[r_side] = 1'b1;
                    n_side         = r_side + 2'd1;
                end else begin
                    n_pos   = side_start;
                    n_end   = side_end;
                    n_fix   = side_fix;
                    n_vert  = side_vert;
                    n_iss   = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // issue one pixel read a cycle, check the data in the cycle after
                if (r_iss) begin
                    n_rd_vld  = 1'b1;
                    n_rd_last = (r_pos == r_end);
                    if (r_pos == r_end) begin
                        n_iss = 1'b0;
                    end else begin
                        n_pos = r_pos + CW'(1);
                    end
                end
                if (r_rd_vld) begin
                    if (rd_data != FULL) begin
                        // a pixel not inside stops this side for good
                        n_stop[r_side] = 1'b1;
                        n_side         = r_side + 2'd1;
                        n_iss          = 1'b0;
                        n_rd_vld       = 1'b0;
                        n_state        = S_SIDE;
                    end else if (r_rd_last) begin
                        case (r_side)
                            SIDE_LEFT:   n_xl = r_fix;
                            SIDE_BOTTOM: n_yl = r_fix;
                            SIDE_RIGHT:  n_xh = r_fix;
                            SIDE_TOP:    n_yh = r_fix;
                            default: ;
                        endcase
                        n_side   = r_side + 2'd1;
                        n_iss    = 1'b0;
                        n_rd_vld = 1'b0;
                        n_state  = S_SIDE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_iss    <= 1'b0;
            r_rd_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_iss    <= n_iss;
            r_rd_vld <= n_rd_vld;
            r_done   <= n_done;
        end
        r_side    <= n_side;
        r_stop    <= n_stop;
        r_xl      <= n_xl;
        r_xh      <= n_xh;
        r_yl      <= n_yl;
        r_yh      <= n_yh;
        r_pos     <= n_pos;
        r_end     <= n_end;
        r_fix     <= n_fix;
        r_vert    <= n_vert;
        r_rd_last <= n_rd_last;
        r_res_in  <= n_res_in;
        r_res_xl  <= n_res_xl;
        r_res_yl  <= n_res_yl;
        r_res_xh  <= n_res_xh;
        r_res_yh  <= n_res_yh;
    end

    assign o_done        = r_done;
    assign o_seed_inside = r_res_in;
    assign o_x_low       = r_res_xl;
    assign o_y_low       = r_res_yl;
    assign o_x_high      = r_res_xh;
    assign o_y_high      = r_res_yh;

endmodule

// ===== sv/irg_checker.sv =====
// port-level checker for the rectangle grow core, bound to the top level
// depends on irg_pkg and inner_rectangle_grow_core_defines.svh
`include "inner_rectangle_grow_core_defines.svh"

module irg_checker #(
    parameter int MAX_DIM = irg_pkg::IRG_MAX_DIM,
    localparam int CW     = $clog2(MAX_DIM)
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          i_opcode,
    input logic          o_done,
    input logic          o_seed_inside,
    input logic [CW-1:0] o_x_low,
    input logic [CW-1:0] o_y_low,
    input logic [CW-1:0] o_x_high,
    input logic [CW-1:0] o_y_high
);

    logic acc_grow, acc_write;

    assign acc_grow  = start && !busy && (i_opcode == irg_pkg::OP_GROW);
    assign acc_write = start && !busy && (i_opcode == irg_pkg::OP_WRITE);

    // a result only closes a grow item that was in progress
    `IRG_ASSERT_IMPL(a_done_after_busy, i_clk, i_rst_n, o_done, $past(busy))

    // a grow item holds the block busy
    `IRG_ASSERT_NEXT(a_grow_busy, i_clk, i_rst_n, acc_grow, busy)

    // a write item finishes at once and gives no result
    `IRG_ASSERT_NEXT(a_write_quiet, i_clk, i_rst_n, acc_write, !busy && !o_done)

    // rejected seed carries zero bounds
    `IRG_ASSERT_IMPL(a_reject_zero, i_clk, i_rst_n, o_done && !o_seed_inside, (o_x_low == '0) && (o_y_low == '0) && (o_x_high == '0) && (o_y_high == '0))

    // grown rectangle is well ordered
    `IRG_ASSERT_IMPL(a_bounds_order, i_clk, i_rst_n, o_done && o_seed_inside, (o_x_low <= o_x_high) && (o_y_low <= o_y_high))

endmodule

bind inner_rectangle_grow_core irg_checker #(.MAX_DIM(MAX_DIM)) u_irg_checker (.*);

// ===== tb/tb.sv =====
// self-checking testbench of the rectangle grow core: pixel writes, grow queries, dim registers
// depends on irg_pkg and inner_rectangle_grow_core; builds the expected rectangles itself
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD  = 8;
    localparam int ROW         = irg_pkg::IRG_MAX_DIM;
    localparam int CW          = $clog2(irg_pkg::IRG_MAX_DIM);
    localparam int IW          = 2 * CW;
    localparam int FB          = irg_pkg::IRG_FULLNESS_BITS;
    localparam int STORE_DEPTH = irg_pkg::IRG_MAX_DIM * irg_pkg::IRG_MAX_DIM;
    localparam int FULL_VALUE  = (1 << FB) - 1;
    // even with every item a worst-case grow the run stays far below this
    localparam int LIMIT_CYCLES = 10_000_000;
    // a write item raises no busy, so a short settle is enough
    localparam int SETTLE_CYCLES = 4;

    // expected outcome of one grow item
    typedef struct {
        bit          seed_ok;
        bit [CW-1:0] x_lo;
        bit [CW-1:0] y_lo;
        bit [CW-1:0] x_hi;
        bit [CW-1:0] y_hi;
    } t_grow_rect;

    // every block input starts at a known value
    logic          i_clk         = 1'b0;
    logic          i_rst_n       = 1'b0;
    logic          start         = 1'b0;
    logic          i_opcode      = irg_pkg::OP_WRITE;
    logic [IW-1:0] i_pixel_index = '0;
    logic [FB-1:0] i_fullness    = '0;
    logic          psel          = 1'b0;
    logic          penable       = 1'b0;
    logic          pwrite        = 1'b0;
    logic [2:0]    paddr         = '0;
    logic [31:0]   pwdata        = '0;
    logic          busy;
    logic          o_done;
    logic          o_seed_inside;
    logic [CW-1:0] o_x_low;
    logic [CW-1:0] o_y_low;
    logic [CW-1:0] o_x_high;
    logic [CW-1:0] o_y_high;
    logic [31:0]   prdata;
    logic          pready;

    // shadow of the block: pixel fullness and the raw dim registers
    bit [FB-1:0] fullness_mem [STORE_DEPTH];
    bit [6:0]    dim_x_reg = 7'd64;
    bit [6:0]    dim_y_reg = 7'd64;

    t_grow_rect  pending_rects[$];   // grow results still to come, oldest first
    int          mismatch_count = 0;
    int          idle_pct = 0;       // chance in percent that the sender skips a cycle

    inner_rectangle_grow_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_opcode      (i_opcode),
        .i_pixel_index (i_pixel_index),
        .i_fullness    (i_fullness),
        .o_done        (o_done),
        .o_seed_inside (o_seed_inside),
        .o_x_low       (o_x_low),
        .o_y_low       (o_y_low),
        .o_x_high      (o_x_high),
        .o_y_high      (o_y_high),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // register value 0 behaves as 1, anything above the store size as the store size
    function automatic int eff_dim(bit [6:0] raw);
        if (raw == 0) return 1;
        if (raw > irg_pkg::IRG_MAX_DIM) return irg_pkg::IRG_MAX_DIM;
        return raw;
    endfunction

    function automatic bit pixel_full(int x, int y, int dx);
        int id;
        id = y * dx + x;
        if (id >= STORE_DEPTH) return 1'b0;
        return fullness_mem[id] == FULL_VALUE;
    endfunction

    // column x across rows ylo..yhi
    function automatic bit column_full(int x, int ylo, int yhi, int dx);
        for (int y = ylo; y <= yhi; y++)
            if (!pixel_full(x, y, dx)) return 1'b0;
        return 1'b1;
    endfunction

    // row y across columns xlo..xhi
    function automatic bit row_full(int y, int xlo, int xhi, int dx);
        for (int x = xlo; x <= xhi; x++)
            if (!pixel_full(x, y, dx)) return 1'b0;
        return 1'b1;
    endfunction

    // greedy growth from the seed: left, bottom, right, top per round until all sides stop
    function automatic t_grow_rect predict_grow(int seed);
        t_grow_rect r;
        int dx, dy, xl, xh, yl, yh;
        bit stop_l, stop_b, stop_r, stop_t;
        r = '{default: 0};
        dx = eff_dim(dim_x_reg);
        dy = eff_dim(dim_y_reg);
        // seed outside the raster or not full: error, bounds stay zero
        if (seed >= dx * dy) return r;
        xl = seed % dx;
        yl = seed / dx;
        if (!pixel_full(xl, yl, dx)) return r;
        xh = xl;
        yh = yl;
        stop_l = 0;
        stop_b = 0;
        stop_r = 0;
        stop_t = 0;
        while (!(stop_l && stop_b && stop_r && stop_t)) begin
            if (!stop_l) begin
                if (xl == 0 || !column_full(xl - 1, yl, yh, dx)) stop_l = 1;
                else xl--;
            end
            if (!stop_b) begin
                if (yl == 0 || !row_full(yl - 1, xl, xh, dx)) stop_b = 1;
                else yl--;
            end
            if (!stop_r) begin
                if (xh + 1 >= dx || !column_full(xh + 1, yl, yh, dx)) stop_r = 1;
                else xh++;
            end
            if (!stop_t) begin
                if (yh + 1 >= dy || !row_full(yh + 1, xl, xh, dx)) stop_t = 1;
                else yh++;
            end
        end
        r.seed_ok = 1'b1;
        r.x_lo    = CW'(xl);
        r.y_lo    = CW'(yl);
        r.x_hi    = CW'(xh);
        r.y_hi    = CW'(yh);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what);
        $display("mismatch at %0t ns: %s", $realtime, what);
        mismatch_count++;
    endtask

    // o_done marks a result for exactly one cycle; compare it with the oldest grow item
    always @(posedge i_clk) begin : result_check
        t_grow_rect want;
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (pending_rects.size() == 0) begin
                report_mismatch("result strobe with no grow item pending");
            end else begin
                want = pending_rects.pop_front();
                if (o_seed_inside !== want.seed_ok)
                    report_mismatch($sformatf("seed_inside got %b want %b",
                                              o_seed_inside, want.seed_ok));
                if (o_x_low !== want.x_lo)
                    report_mismatch($sformatf("x_low got %0d want %0d", o_x_low, want.x_lo));
                if (o_y_low !== want.y_lo)
                    report_mismatch($sformatf("y_low got %0d want %0d", o_y_low, want.y_lo));
                if (o_x_high !== want.x_hi)
                    report_mismatch($sformatf("x_high got %0d want %0d", o_x_high, want.x_hi));
                if (o_y_high !== want.y_hi)
                    report_mismatch($sformatf("y_high got %0d want %0d", o_y_high, want.y_hi));
            end
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // one item: optional idle cycles, then hold start until an edge sees busy low
    // start stays high into the next item when no gap is drawn, so it is never
    // dropped and raised within one step
    task automatic send_item(logic op, int idx, int fill);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start         <= 1'b1;
        i_opcode      <= op;
        i_pixel_index <= idx[IW-1:0];
        i_fullness    <= fill[FB-1:0];
        do @(posedge i_clk); while (busy !== 1'b0);
        // accepted at this edge: update the shadow or queue the expected rectangle
        if (op == irg_pkg::OP_WRITE) fullness_mem[idx[IW-1:0]] = fill[FB-1:0];
        else pending_rects.insert(pending_rects.size(), predict_grow(idx));
    endtask

    // hold off until every grow result is in, then let trailing writes settle
    task automatic wait_results_drained();
        start <= 1'b0;
        while (pending_rects.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register write (setup + access), psel dropped, then a read back of the low 7 bits
    // upper data bits are random: the register keeps only 7 of them
    task automatic write_dim_reg(logic reg_idx, int unsigned value);
        logic [31:0] word;
        word      = $urandom;
        word[6:0] = value[6:0];
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (reg_idx == irg_pkg::REG_DIM_X) dim_x_reg = word[6:0];
        else dim_y_reg = word[6:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        psel    <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata[6:0] !== word[6:0])
            report_mismatch($sformatf("register %0d read back %0d want %0d",
                                      reg_idx, prdata[6:0], word[6:0]));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // the store is not cleared by reset: every pixel a later query can reach is written
    // rows 0..7 full with an empty row 8 above, top row full with an empty pixel below
    task automatic test_fill_store();
        for (int i = 0; i < 8 * ROW; i++)
            send_item(irg_pkg::OP_WRITE, i, FULL_VALUE);
        for (int i = 8 * ROW; i < 9 * ROW; i++)
            send_item(irg_pkg::OP_WRITE, i, 0);
        for (int i = STORE_DEPTH - ROW; i < STORE_DEPTH; i++)
            send_item(irg_pkg::OP_WRITE, i, FULL_VALUE);
        send_item(irg_pkg::OP_WRITE, STORE_DEPTH - ROW - 2, 0);
        wait_results_drained();
    endtask

    // 64x64 raster: growth from the two far corners fills rows 0..7 and the whole top row
    task automatic test_full_raster_grow();
        send_item(irg_pkg::OP_GROW, 0, 0);
        send_item(irg_pkg::OP_GROW, STORE_DEPTH - 1, 0);
        wait_results_drained();
    endtask

    // seeds that are partly full or empty, and growth stopped by non-full pixels
    task automatic test_seed_not_full();
        send_item(irg_pkg::OP_WRITE, 100, 0);
        send_item(irg_pkg::OP_WRITE, 101, 1);
        send_item(irg_pkg::OP_WRITE, 102, 2);
        send_item(irg_pkg::OP_GROW, 100, FULL_VALUE);
        send_item(irg_pkg::OP_GROW, 101, 0);
        send_item(irg_pkg::OP_GROW, 102, 0);
        // seed at (20,3): a hole above at (20,6) and one to the left at (15,3)
        send_item(irg_pkg::OP_WRITE, 6 * 64 + 20, 0);
        send_item(irg_pkg::OP_WRITE, 3 * 64 + 15, 1);
        send_item(irg_pkg::OP_GROW, 3 * 64 + 20, 0);
        wait_results_drained();
    endtask

    // small raster with seeds past its end, then zero and oversized dim values
    task automatic test_dim_extremes();
        write_dim_reg(irg_pkg::REG_DIM_X, 5);
        write_dim_reg(irg_pkg::REG_DIM_Y, 5);
        send_item(irg_pkg::OP_GROW, 24, 0);
        send_item(irg_pkg::OP_GROW, 25, 0);
        send_item(irg_pkg::OP_GROW, STORE_DEPTH - 1, 0);
        wait_results_drained();
        // zero acts as one: a single pixel raster
        write_dim_reg(irg_pkg::REG_DIM_X, 0);
        write_dim_reg(irg_pkg::REG_DIM_Y, 0);
        send_item(irg_pkg::OP_GROW, 0, 0);
        send_item(irg_pkg::OP_GROW, 1, 0);
        wait_results_drained();
        // oversized width clamps to a full row, one pixel high
        write_dim_reg(irg_pkg::REG_DIM_X, 127);
        write_dim_reg(irg_pkg::REG_DIM_Y, 1);
        send_item(irg_pkg::OP_GROW, 63, 0);
        send_item(irg_pkg::OP_GROW, 64, 0);
        wait_results_drained();
        // one pixel wide, full height, oversized height clamped
        write_dim_reg(irg_pkg::REG_DIM_X, 1);
        write_dim_reg(irg_pkg::REG_DIM_Y, 127);
        send_item(irg_pkg::OP_GROW, 40, 0);
        send_item(irg_pkg::OP_GROW, 70, 0);
        wait_results_drained();
    endtask

    // random traffic under several raster shapes: painted blocks of full or
    // holed pixels, stray writes, and seeds mostly inside the raster
    task automatic test_random_traffic(int pct, int shapes, int items_per_shape);
        int unsigned rx, ry;
        int dx, dy, sent, w, h, x0, y0, fill, pick;
        for (int s = 0; s < shapes; s++) begin
            // register writes only while the block is idle
            idle_pct = 0;
            wait_results_drained();
            case ($urandom_range(7))
                0: begin rx = 64;                     ry = $urandom_range(1, 4);    end
                1: begin rx = $urandom_range(1, 4);   ry = 64;                      end
                2: begin rx = 0;                      ry = $urandom_range(0, 8);    end
                3: begin rx = $urandom_range(1, 8);   ry = 0;                       end
                4: begin rx = $urandom_range(65, 127); ry = $urandom_range(1, 3);   end
                5: begin rx = $urandom_range(1, 3);   ry = $urandom_range(65, 127); end
                default: begin rx = $urandom_range(2, 12); ry = $urandom_range(2, 12); end
            endcase
            write_dim_reg(irg_pkg::REG_DIM_X, rx);
            write_dim_reg(irg_pkg::REG_DIM_Y, ry);
            dx = eff_dim(dim_x_reg);
            dy = eff_dim(dim_y_reg);
            idle_pct = pct;
            sent = 0;
            while (sent < items_per_shape) begin
                pick = $urandom_range(9);
                if (pick < 3) begin
                    // paint a block, mostly full, sometimes a hole of one value
                    w    = $urandom_range(1, (dx < 4) ? dx : 4);
                    h    = $urandom_range(1, (dy < 4) ? dy : 4);
                    x0   = $urandom_range(0, dx - w);
                    y0   = $urandom_range(0, dy - h);
                    fill = ($urandom_range(3) == 0) ? $urandom_range(0, FULL_VALUE - 1)
                                                    : FULL_VALUE;
                    for (int y = y0; y < y0 + h; y++)
                        for (int x = x0; x < x0 + w; x++) begin
                            send_item(irg_pkg::OP_WRITE, y * dx + x, fill);
                            sent++;
                        end
                end else if (pick < 5) begin
                    fill = $urandom_range(1) ? FULL_VALUE : $urandom_range(0, FULL_VALUE);
                    send_item(irg_pkg::OP_WRITE, $urandom_range(0, dx * dy - 1), fill);
                    sent++;
                end else begin
                    // query; fullness is don't-care here, so drive it at random
                    if ($urandom_range(9) != 0)
                        send_item(irg_pkg::OP_GROW, $urandom_range(0, dx * dy - 1),
                                  $urandom_range(0, FULL_VALUE));
                    else
                        send_item(irg_pkg::OP_GROW, $urandom_range(0, STORE_DEPTH - 1),
                                  $urandom_range(0, FULL_VALUE));
                    sent++;
                end
            end
        end
        idle_pct = 0;
        wait_results_drained();
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    // run limit: a hung handshake or lost result ends here
    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("FAILURE");
        $finish;
    end

    initial begin
        // synchronous reset, held low from time zero, released once
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_fill_store();
        test_full_raster_grow();
        test_seed_not_full();
        test_dim_extremes();
        // idling phases: none, sender idle about half the cycles, then about a quarter
        test_random_traffic(0, 6, 42);
        test_random_traffic(47, 6, 42);
        test_random_traffic(23, 6, 42);

        // everything accepted and drained; a last quiet stretch catches stray strobes
        wait_results_drained();
        repeat (32) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/irg_pkg.sv
sv/irg_ram.sv
sv/irg_div.sv
sv/inner_rectangle_grow_core.sv
sv/irg_checker.sv
tb/tb.sv
